@@ design/crc8_frame_receiver_resync_macros.svh @@
// assertion macros used by the checker file
`ifndef CRC8_FRAME_RECEIVER_RESYNC_MACROS_SVH
`define CRC8_FRAME_RECEIVER_RESYNC_MACROS_SVH

// same-cycle implication, ignored while reset is held
`define CFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, ignored while reset is held
`define CFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also covers the reset itself
`define CFR_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/crc8fr_pkg.sv @@
// shared types and constants of the crc8 frame receiver
package crc8fr_pkg;

  localparam logic [7:0] SYNC_BYTE     = 8'h00;
  localparam logic [7:0] CRC_START     = 8'hF3;
  localparam logic [7:0] CRC_POLY      = 8'h07;
  localparam logic [7:0] CRC_TOP       = 8'h80;
  localparam logic [7:0] LEN_MASK      = 8'h0F;
  localparam logic [7:0] TIMEOUT_RESET = 8'd10;
  localparam logic [7:0] QUIET_MAX     = 8'hFF;
  localparam int         MAX_OUT       = 32;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  // one classified beat waiting for the back end
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHK0,
    ST_CHK2,
    ST_CRC,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

  // one msb-first crc8 byte update
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] c;
    c = crc ^ d;
    for (int b = 0; b < 8; b++) begin
      if ((c & CRC_TOP) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ design/crc8fr_ram.sv @@
// generic single-port-write ram with registered read
module crc8fr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/crc8fr_front.sv @@
// input side: accepts beats, classifies them and queues them for the back end
module crc8fr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                in_tuser,
  output logic                q_valid,
  output crc8fr_pkg::item_t   q_item,
  input  logic                q_pop
);
  import crc8fr_pkg::*;

  item_t      slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push, pop;
  item_t      item_in;

  // classify the beat
  always_comb begin
    item_in.kind = (in_tuser == 1'b1) ? KIND_TICK : KIND_BYTE;
    item_in.data = in_tdata;
  end

  assign in_tready = (fill_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (fill_r != 2'd0);
  assign pop       = q_pop && q_valid;
  assign q_item    = slot_r[rd_ptr_r];

  // queue pointers
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

@@ design/crc8fr_back.sv @@
// back end: ring buffer, frame scan, crc check and frame output
module crc8fr_back #(
  parameter int BUFFER_BYTES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  crc8fr_pkg::item_t q_item,
  output logic              q_pop,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tuser,
  output logic              out_tlast
);
  import crc8fr_pkg::*;

  localparam int PW = $clog2(BUFFER_BYTES);
  localparam int CW = $clog2(BUFFER_BYTES + 1);
  localparam int OW = $clog2(MAX_OUT + 1);
  localparam logic [PW:0]   BUF_P = (PW + 1)'(BUFFER_BYTES);
  localparam logic [CW-1:0] BUF_C = CW'(BUFFER_BYTES);
  localparam logic [OW-1:0] MAX_O = OW'(MAX_OUT);

  state_t        state_r, state_nxt;
  logic [PW-1:0] head_r, head_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    quiet_r, quiet_nxt;
  logic [7:0]    timeout_r;
  logic [CW-1:0] total_r, total_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [7:0]    crc_r, crc_nxt;
  logic [OW-1:0] prod_r, prod_nxt;
  logic          ov_r, ov_nxt;
  logic [7:0]    ob_r, ob_nxt;
  logic          of_r, of_nxt;
  logic          ol_r, ol_nxt;

  logic          wr_en;
  logic [PW-1:0] wr_addr;
  logic [CW-1:0] wr_cnt;
  logic [CW-1:0] rd_off;
  logic [PW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic [CW-1:0] len_total;
  logic          out_free;
  logic          emit_last;
  logic [7:0]    quiet_inc;

  // ring position: head plus offset, folded once
  function automatic logic [PW-1:0] ring_pos(input logic [PW-1:0] h, input logic [CW-1:0] o);
    logic [PW+1:0] s;
    s = {2'b00, h} + (PW + 2)'(o);
    if (s >= {1'b0, BUF_P}) begin
      s = s - {1'b0, BUF_P};
    end
    return s[PW-1:0];
  endfunction

  crc8fr_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (q_item.data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_tvalid = ov_r;
  assign out_tdata  = ob_r;
  assign out_tuser  = of_r;
  assign out_tlast  = ol_r;
  assign out_free   = !ov_r || out_tready;
  assign len_total  = CW'(4) + CW'(rd_data & LEN_MASK);
  assign emit_last  = (idx_r + CW'(2) == total_r);
  assign quiet_inc  = (quiet_r == QUIET_MAX) ? QUIET_MAX : quiet_r + 8'd1;
  assign q_pop      = (state_r == ST_IDLE);
  assign wr_cnt     = (cnt_r >= BUF_C) ? '0 : cnt_r;
  assign wr_en      = (state_r == ST_IDLE) && q_valid && (q_item.kind == KIND_BYTE);
  assign wr_addr    = ring_pos(head_r, wr_cnt);
  assign rd_addr    = ring_pos(head_r, rd_off);

  // read offset issued in each state
  always_comb begin
    unique case (state_r)
      ST_CHK0:     rd_off = CW'(2);
      ST_CHK2:     rd_off = CW'(1);
      ST_CRC:      rd_off = idx_r + CW'(1);
      ST_EMIT_RD,
      ST_EMIT_OUT: rd_off = idx_r;
      default:     rd_off = '0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && q_item.kind == KIND_BYTE) state_nxt = ST_SCAN;
      end
      ST_SCAN: state_nxt = (cnt_r == '0) ? ST_IDLE : ST_CHK0;
      ST_CHK0: begin
        if (rd_data != SYNC_BYTE) state_nxt = ST_SCAN;
        else if (cnt_r < CW'(3)) state_nxt = ST_IDLE;
        else state_nxt = ST_CHK2;
      end
      ST_CHK2: begin
        if (len_total > BUF_C) state_nxt = ST_SCAN;
        else if (cnt_r < len_total) state_nxt = ST_IDLE;
        else state_nxt = ST_CRC;
      end
      ST_CRC: begin
        if (idx_r + CW'(1) == total_r) begin
          state_nxt = (rd_data == crc_r) ? ST_EMIT_RD : ST_SCAN;
        end
      end
      ST_EMIT_RD: state_nxt = ST_EMIT_OUT;
      ST_EMIT_OUT: begin
        if (out_free || prod_r >= MAX_O) state_nxt = emit_last ? ST_SCAN : ST_EMIT_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    head_nxt  = head_r;
    cnt_nxt   = cnt_r;
    quiet_nxt = quiet_r;
    total_nxt = total_r;
    idx_nxt   = idx_r;
    crc_nxt   = crc_r;
    prod_nxt  = prod_r;
    ov_nxt    = ov_r && !out_tready;
    ob_nxt    = ob_r;
    of_nxt    = of_r;
    ol_nxt    = ol_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          prod_nxt = '0;
          if (q_item.kind == KIND_BYTE) begin
            cnt_nxt   = wr_cnt + CW'(1);
            quiet_nxt = '0;
          end else begin
            quiet_nxt = quiet_inc;
            if (cnt_r != '0 && quiet_inc > timeout_r) cnt_nxt = '0;
          end
        end
      end
      ST_CHK0: begin
        if (rd_data != SYNC_BYTE) begin
          head_nxt = ring_pos(head_r, CW'(1));
          cnt_nxt  = cnt_r - CW'(1);
        end
      end
      ST_CHK2: begin
        total_nxt = len_total;
        idx_nxt   = CW'(1);
        crc_nxt   = CRC_START;
        if (len_total > BUF_C) begin
          head_nxt = ring_pos(head_r, CW'(1));
          cnt_nxt  = cnt_r - CW'(1);
        end
      end
      ST_CRC: begin
        if (idx_r + CW'(1) == total_r) begin
          idx_nxt = CW'(1);
          if (rd_data != crc_r) begin
            head_nxt = ring_pos(head_r, CW'(1));
            cnt_nxt  = cnt_r - CW'(1);
          end
        end else begin
          crc_nxt = crc8_byte(crc_r, rd_data);
          idx_nxt = idx_r + CW'(1);
        end
      end
      ST_EMIT_OUT: begin
        if (prod_r >= MAX_O || out_free) begin
          if (prod_r < MAX_O) begin
            ov_nxt   = 1'b1;
            ob_nxt   = rd_data;
            of_nxt   = (idx_r == CW'(1));
            ol_nxt   = emit_last;
            prod_nxt = prod_r + OW'(1);
          end
          idx_nxt = idx_r + CW'(1);
          if (emit_last) begin
            head_nxt = ring_pos(head_r, total_r);
            cnt_nxt  = cnt_r - total_r;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      head_r    <= '0;
      cnt_r     <= '0;
      quiet_r   <= '0;
      prod_r    <= '0;
      ov_r      <= 1'b0;
      timeout_r <= TIMEOUT_RESET;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      quiet_r <= quiet_nxt;
      prod_r  <= prod_nxt;
      ov_r    <= ov_nxt;
      if (cfg_wr_en) timeout_r <= cfg_wr_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    total_r <= total_nxt;
    idx_r   <= idx_nxt;
    crc_r   <= crc_nxt;
    ob_r    <= ob_nxt;
    of_r    <= of_nxt;
    ol_r    <= ol_nxt;
  end

endmodule

@@ design/crc8_frame_receiver_resync.sv @@
// top level of the crc8 frame receiver with resync
//
//  channel | dir | handshake               | payload
//  in_     | in  | in_tvalid / in_tready   | tdata = rx_byte, tuser = cmd
//  out_    | out | out_tvalid / out_tready | tdata = frame_byte, tuser = frame_first,
//          |     |                         | tlast = frame_last
//  cfg_    | in  | cfg_wr_en               | cfg_wr_data = silence_timeout_ms
//
// a tick is handled by the back end in its idle state; a byte enters the buffer there, then each
// scan pass tests for an empty buffer, then checks the sync byte, then reads the length, then
// runs the crc over the frame, then reads and sends each emitted byte, waiting on output stalls
// the back-end sequencer and its single ram read port set this order of steps
// a 2-beat queue lets input be taken while the back end scans or output stalls
// reset (rst_n low, synchronous) empties buffer and queue, timeout returns to 10
module crc8_frame_receiver_resync #(
  parameter int BUFFER_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  input  logic       in_tuser,   // [0] cmd
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] frame_byte
  output logic       out_tuser,  // [0] frame_first
  output logic       out_tlast,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);
  import crc8fr_pkg::*;

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  crc8fr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  crc8fr_back #(.BUFFER_BYTES(BUFFER_BYTES)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

@@ design/crc8fr_checker.sv @@
// port-level checker for the crc8 frame receiver, bound to the top level
`include "crc8_frame_receiver_resync_macros.svh"

module crc8fr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);

  // a stalled beat stays, with its payload unchanged
  `CFR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "out beat dropped or changed while stalled")
  // reset leaves no beat pending
  `CFR_ASSERT_RST(a_rst_quiet, !rst_n, !out_tvalid, "out beat valid after reset")
  // a frame has at least address and header, so first never ends it
  `CFR_ASSERT_NOW(a_first_not_last, out_tvalid, !(out_tuser && out_tlast), "frame of one byte")
  // after a last beat the next frame starts with its first byte
  `CFR_ASSERT_NEXT(a_last_then_first, out_tvalid && out_tready && out_tlast && $past(1'b1), !out_tvalid || out_tuser, "frame did not start with address byte")

endmodule

bind crc8_frame_receiver_resync crc8fr_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

@@ tb/tb_top.sv @@
// testbench for the crc8 frame receiver: driver, monitor and frame predictor
`timescale 1ns / 100ps

module tb_top;
  import crc8fr_pkg::*;

  localparam int BUF_BYTES = 32;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } rx_beat_t;

  typedef struct packed {
    logic [7:0] fbyte;
    logic       first;
    logic       last;
  } frame_beat_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] rx_byte
  logic       in_tuser;   // [0] cmd
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] frame_byte
  logic       out_tuser;  // [0] frame_first
  logic       out_tlast;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  crc8_frame_receiver_resync #(.BUFFER_BYTES(BUF_BYTES)) DUT (.*);

  // predictor state
  logic [7:0]  rx_store [BUF_BYTES];
  int          rx_count;
  int          quiet_cnt;
  logic [7:0]  timeout_ms;

  rx_beat_t    pending_q [$];
  frame_beat_t frame_q [$];
  int          fail_cnt;
  int          cycle_cnt;
  bit          calm;
  bit          drive_done;
  bit          in_taken;
  int          in_gap;
  int          out_gap;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // crc over stored bytes from index lo, n bytes
  function automatic logic [7:0] stored_crc(int lo, int n);
    logic [7:0] c;
    c = CRC_START;
    for (int i = lo; i < lo + n; i++) begin
      c = c ^ rx_store[i];
      for (int b = 0; b < 8; b++) c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  task automatic drop_lead(int n);
    if (n >= rx_count) begin
      rx_count = 0;
    end else begin
      for (int i = 0; i < rx_count - n; i++) rx_store[i] = rx_store[i + n];
      rx_count -= n;
    end
  endtask

  // apply one accepted beat and queue the frame bytes it completes
  task automatic predict_frames(rx_beat_t bt);
    int total;
    int made;
    made = 0;
    if (bt.kind == KIND_TICK) begin
      if (quiet_cnt < 255) quiet_cnt++;
      if (rx_count > 0 && quiet_cnt > timeout_ms) rx_count = 0;
      return;
    end
    if (rx_count >= BUF_BYTES) rx_count = 0;
    rx_store[rx_count] = bt.data;
    rx_count++;
    quiet_cnt = 0;
    while (rx_count >= 1) begin
      if (rx_store[0] != SYNC_BYTE) begin
        drop_lead(1);
        continue;
      end
      if (rx_count < 3) break;
      total = 4 + (rx_store[2] & LEN_MASK);
      if (total > BUF_BYTES) begin
        drop_lead(1);
        continue;
      end
      if (rx_count < total) break;
      if (stored_crc(1, total - 2) == rx_store[total - 1]) begin
        for (int i = 1; i + 1 < total; i++) begin
          if (made < MAX_OUT) begin
            frame_q.push_back('{rx_store[i], i == 1, i + 2 == total});
            made++;
          end
        end
        drop_lead(total);
      end else begin
        drop_lead(1);
      end
    end
  endtask

  // crc of a byte list, used to build good frames
  function automatic logic [7:0] list_crc(logic [7:0] bytes [$]);
    logic [7:0] c;
    c = CRC_START;
    foreach (bytes[i]) begin
      c = c ^ bytes[i];
      for (int b = 0; b < 8; b++) c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  task automatic push_byte(logic [7:0] d);
    pending_q.push_back('{KIND_BYTE, d});
  endtask

  task automatic push_tick();
    pending_q.push_back('{KIND_TICK, 8'($urandom_range(0, 255))});
  endtask

  // sync, address, header, payload, crc; corrupt flips one crc bit
  task automatic push_frame(logic [7:0] addr, logic [3:0] plen, bit corrupt);
    logic [7:0] body [$];
    logic [7:0] c;
    body.push_back(addr);
    body.push_back({4'($urandom_range(0, 15)), plen});
    for (int i = 0; i < plen; i++) body.push_back(8'($urandom_range(0, 255)));
    c = list_crc(body);
    if (corrupt) c ^= 8'(1 << $urandom_range(0, 7));
    push_byte(SYNC_BYTE);
    foreach (body[i]) push_byte(body[i]);
    push_byte(c);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_taken) begin
        void'(pending_q.pop_front());
      end
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (!calm && !(in_tvalid && !in_taken) && $urandom_range(0, 15) == 0) begin
        in_gap <= $urandom_range(1, 19);
        in_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_tvalid <= 1'b1;
        {in_tuser, in_tdata} <= pending_q[0];
      end else begin
        in_tvalid <= 1'b0;
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        out_gap <= $urandom_range(1, 19);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) predict_frames({kind_t'(in_tuser), in_tdata});
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_q.size() == 0) begin
        $error("unexpected frame beat %h", out_tdata);
        fail_cnt++;
      end else begin
        frame_beat_t ex;
        ex = frame_q.pop_front();
        if (out_tdata !== ex.fbyte) begin
          $error("frame_byte expected %h got %h", ex.fbyte, out_tdata);
          fail_cnt++;
        end
        if (out_tuser !== ex.first) begin
          $error("frame_first expected %b got %b", ex.first, out_tuser);
          fail_cnt++;
        end
        if (out_tlast !== ex.last) begin
          $error("frame_last expected %b got %b", ex.last, out_tlast);
          fail_cnt++;
        end
      end
    end
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // wait for all queued beats to be taken and all frames to arrive
  task automatic drain();
    while (pending_q.size() > 0 || in_tvalid) @(posedge clk);
    while (frame_q.size() > 0) @(posedge clk);
    repeat (1000) @(posedge clk);
  endtask

  task automatic write_timeout(logic [7:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    timeout_ms = v;
  endtask

  task automatic random_phase(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 55) push_frame(8'($urandom_range(0, 255)), 4'($urandom_range(0, 6)), 1'b0);
      else if (k < 62) push_frame(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)), 1'b0);
      else if (k < 72) push_frame(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)), 1'b1);
      else if (k < 88) push_byte(8'($urandom_range(0, 255)));
      else if (k < 93) push_byte(SYNC_BYTE);
      else repeat ($urandom_range(1, 12)) push_tick();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 8'h00;
    rx_count = 0;
    quiet_cnt = 0;
    timeout_ms = TIMEOUT_RESET;
    fail_cnt = 0;
    cycle_cnt = 0;
    calm = 1'b0;
    in_taken = 1'b0;
    in_gap = 0;
    out_gap = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes of length and address, bad crc, stray bytes, silence
    push_frame(8'h00, 4'd0, 1'b0);
    push_frame(8'hFF, 4'd15, 1'b0);
    push_frame(8'h5A, 4'd3, 1'b1);
    push_byte(8'hFF);
    push_byte(8'h80);
    push_frame(8'h01, 4'd1, 1'b0);
    push_byte(SYNC_BYTE);
    push_byte(8'h12);
    repeat (12) push_tick();
    push_frame(8'hA5, 4'd2, 1'b0);
    drain();

    // timeout of zero: a single tick clears partial data
    write_timeout(8'd0);
    push_byte(SYNC_BYTE);
    push_byte(8'h33);
    push_tick();
    push_frame(8'h7E, 4'd4, 1'b0);
    random_phase(4);
    drain();

    // timeout of 255 never clears, even once the quiet count saturates
    write_timeout(8'd255);
    repeat (3) push_byte(SYNC_BYTE);
    repeat (260) push_tick();
    random_phase(4);
    drain();

    write_timeout(8'($urandom_range(1, 20)));
    random_phase(4);
    drain();

    write_timeout(TIMEOUT_RESET);
    calm = 1'b1;
    random_phase(4);
    drain();

    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
